@@ rtl/aacsfp_pkg.sv @@
// Shared types, constants and the frame length clamp of the audio super-frame partitioner.
package aacsfp_pkg;

    localparam int MAX_FRAMES_DEF   = 10;
    localparam int BORDER_WIDTH_DEF = 12;

    localparam int FRAMES_LO  = 5;
    localparam int FRAMES_HI  = 10;
    localparam int TEXT_BYTES = 4;
    localparam int BYTE_W     = 8;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_W       = 12;
    localparam int OFF_W       = 12;
    localparam int FI_W        = 4;
    localparam int LEN_MAX     = (1 << LEN_W) - 1;
    localparam int HP_W        = $clog2((1 << CFG_W) / FRAMES_LO + 1);
    localparam int PAY_W       = 15;
    localparam int SZ_W        = 18;
    localparam int RECIP_SHIFT = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HPROT = 2'd3;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HIGHER = 2'd1,
        KIND_CRC    = 2'd2,
        KIND_LOWER  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              block_start;
    } t_in;

    typedef struct packed {
        t_kind             kind;
        logic [FI_W-1:0]   frame_index;
        logic [OFF_W-1:0]  byte_offset;
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  frame_length;
        logic              header_good;
        logic              frame_end;
    } t_out;

    // A length below the higher-protected count is raised to it, one above the payload
    // length is lowered to it, and the result is kept within the length field.
    function automatic logic [LEN_W-1:0] clamp_len(input logic signed [SZ_W-1:0] size,
                                                   input logic [HP_W-1:0] hp,
                                                   input logic signed [PAY_W-1:0] pl);
        logic signed [SZ_W-1:0] s;
        logic signed [SZ_W-1:0] hps;
        logic signed [SZ_W-1:0] pls;
        hps = SZ_W'(hp);
        pls = SZ_W'(pl);
        s   = size;
        if (s < hps) begin
            s = hps;
        end else if (s > pls) begin
            s = pls;
        end
        if (s < 0) begin
            s = '0;
        end else if (s > LEN_MAX) begin
            s = SZ_W'(LEN_MAX);
        end
        return s[LEN_W-1:0];
    endfunction

endpackage

@@ rtl/aacsfp_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module aacsfp_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/aacsfp_skid.sv @@
// Two-entry output buffer that lets the block take an item while a result waits.
module aacsfp_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  aacsfp_pkg::t_out  i_item,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output aacsfp_pkg::t_out  o_item
);

    import aacsfp_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out_item;
    t_out r_skid_item;
    logic n_out_valid;
    logic n_skid_valid;
    logic pop;
    logic load_from_in;
    logic load_from_skid;
    logic load_skid;

    always_comb begin
        pop            = r_out_valid && !i_stall;
        n_out_valid    = r_out_valid;
        n_skid_valid   = r_skid_valid;
        load_from_in   = 1'b0;
        load_from_skid = 1'b0;
        load_skid      = 1'b0;
        if (r_skid_valid) begin
            if (pop) begin
                load_from_skid = 1'b1;
                n_skid_valid   = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || pop) begin
                load_from_in = 1'b1;
                n_out_valid  = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_from_in) begin
            r_out_item <= i_item;
        end else if (load_from_skid) begin
            r_out_item <= r_skid_item;
        end
        if (load_skid) begin
            r_skid_item <= i_item;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

@@ rtl/aac_superframe_partitioner.sv @@
// Top level of the audio super-frame partitioner: header parsing and payload byte labeling.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_stall      i_in_item  (data_byte, block_start)
//   output    out        o_out_valid / i_out_stall    o_out_item (kind ... frame_end)
//   config    in         i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// One item is taken every cycle unless the input stalls; its result, if any, is registered.
// Frame lengths but the last live in a small RAM whose read address follows the next frame,
// so the current frame's length is ready when its bytes arrive; the last sits in a register.
// Reset is synchronous and active low and needs no clearing pass.
// The input stalls only while both entries of the output buffer hold results.
module aac_superframe_partitioner #(
    parameter int MAX_FRAMES   = aacsfp_pkg::MAX_FRAMES_DEF,
    parameter int BORDER_WIDTH = aacsfp_pkg::BORDER_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  aacsfp_pkg::t_in                  i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output aacsfp_pkg::t_out                 o_out_item,
    input  logic                             i_cfg_wr_en,
    input  logic [aacsfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aacsfp_pkg::CFG_W-1:0]     i_cfg_data
);

    import aacsfp_pkg::*;

    localparam int BW     = BORDER_WIDTH;
    localparam int AW     = $clog2(MAX_FRAMES);
    localparam int FW     = $clog2(MAX_FRAMES + 1);
    localparam int LW     = $clog2(BW);
    localparam int AVW    = $clog2(BW + BYTE_W);
    localparam int CAT_W  = BW - 1 + BYTE_W;
    localparam int NLO    = FRAMES_LO;
    localparam int NHI    = (FRAMES_HI > MAX_FRAMES) ? MAX_FRAMES : FRAMES_HI;
    localparam int HDR_LO = ((NLO - 1) * BW + 7) / 8;
    localparam int HDR_HI = ((NHI - 1) * BW + 7) / 8;
    localparam int HCW    = $clog2(HDR_HI + 1);
    localparam int PROD_W = CFG_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP_LO =
        RECIP_SHIFT'(((1 << RECIP_SHIFT) + NLO - 1) / NLO);
    localparam logic [RECIP_SHIFT-1:0] RECIP_HI =
        RECIP_SHIFT'(((1 << RECIP_SHIFT) + NHI - 1) / NHI);

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_HIGHER = 4'b0010,
        PH_LOWER  = 4'b0100,
        PH_IDLE   = 4'b1000
    } t_phase;

    // Configuration and the values derived from it.
    logic                    r_rate;
    logic                    r_text;
    logic [CFG_W-1:0]        r_block;
    logic [CFG_W-1:0]        r_hprot;
    logic [FW-1:0]           r_n;
    logic [HCW-1:0]          r_hdr;
    logic signed [PAY_W-1:0] r_payload;
    logic [HP_W-1:0]         r_hp;

    logic                    c_rate;
    logic                    c_text;
    logic [CFG_W-1:0]        c_block;
    logic [CFG_W-1:0]        c_hprot;
    logic [FW-1:0]           c_n;
    logic [HCW-1:0]          c_hdr;
    logic signed [PAY_W-1:0] c_payload;
    logic signed [PAY_W-1:0] c_v;
    logic [RECIP_SHIFT-1:0]  c_recip;
    logic [PROD_W-1:0]       c_prod;
    logic [HP_W-1:0]         c_hp;

    // Parsing state.
    t_phase              r_phase, n_phase, e_phase;
    logic [HCW-1:0]      r_cnt, n_cnt, e_cnt;
    logic [BW-2:0]       r_bits, n_bits, e_bits;
    logic [LW-1:0]       r_left, n_left, e_left;
    logic [BW-1:0]       r_prev, n_prev, e_prev;
    logic                r_good, n_good, e_good;
    logic [FW-1:0]       r_cur, n_cur, e_cur;
    logic [OFF_W-1:0]    r_off, n_off, e_off;
    logic [LEN_W-1:0]    r_last_len, n_last_len;
    logic [MAX_FRAMES-1:0] r_low, n_low;

    logic                acc;
    logic                res_valid;
    t_out                res;
    logic [FW-1:0]       nb;
    logic [LEN_W-1:0]    ram_q;
    logic [LEN_W-1:0]    cur_len;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [LEN_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;

    logic [CAT_W-1:0]        cat;
    logic [AVW-1:0]          avail;
    logic [AVW-1:0]          shift;
    logic [BW-1:0]           border;
    logic [LW-1:0]           new_left;
    logic [HCW:0]            cnt_inc;
    logic signed [SZ_W-1:0]  sz_border;
    logic signed [SZ_W-1:0]  sz_last;
    logic [LEN_W-1:0]        len_clamped;
    logic [LEN_W-1:0]        last_clamped;
    logic [OFF_W:0]          off_inc;
    logic [FW-1:0]           nl;

    function automatic logic [FW-1:0] next_lower(input logic [MAX_FRAMES-1:0] low,
                                                 input logic [FW-1:0] start,
                                                 input logic [FW-1:0] n);
        logic [FW-1:0] r;
        r = n;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (FW'(i) >= start && FW'(i) < n && low[i]) begin
                r = FW'(i);
            end
        end
        return r;
    endfunction

    always_comb begin
        c_rate  = (i_cfg_wr_en && i_cfg_index == CFG_RATE) ? i_cfg_data[0] : r_rate;
        c_text  = (i_cfg_wr_en && i_cfg_index == CFG_TEXT) ? i_cfg_data[0] : r_text;
        c_block = (i_cfg_wr_en && i_cfg_index == CFG_BLOCK) ? i_cfg_data : r_block;
        c_hprot = (i_cfg_wr_en && i_cfg_index == CFG_HPROT) ? i_cfg_data : r_hprot;
        c_n     = c_rate ? FW'(NHI) : FW'(NLO);
        c_hdr   = c_rate ? HCW'(HDR_HI) : HCW'(HDR_LO);
        c_recip = c_rate ? RECIP_HI : RECIP_LO;
        c_payload = PAY_W'(c_block) - (c_text ? PAY_W'(TEXT_BYTES) : PAY_W'(0))
                    - PAY_W'(c_hdr) - PAY_W'(c_n);
        c_v     = PAY_W'(c_hprot) - PAY_W'(c_hdr) - PAY_W'(c_n);
        c_prod  = c_v[CFG_W-1:0] * c_recip;
        c_hp    = (c_v < 0) ? '0 : HP_W'(c_prod >> RECIP_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= 1'b0;
            r_text    <= 1'b0;
            r_block   <= '0;
            r_hprot   <= '0;
            r_n       <= FW'(NLO);
            r_hdr     <= HCW'(HDR_LO);
            r_payload <= PAY_W'(0) - PAY_W'(HDR_LO) - PAY_W'(NLO);
            r_hp      <= '0;
        end else begin
            r_rate    <= c_rate;
            r_text    <= c_text;
            r_block   <= c_block;
            r_hprot   <= c_hprot;
            r_n       <= c_n;
            r_hdr     <= c_hdr;
            r_payload <= c_payload;
            r_hp      <= c_hp;
        end
    end

    assign acc     = i_in_valid && !o_in_stall;
    assign nb      = r_n - FW'(1);
    assign cur_len = (r_cur == nb) ? r_last_len : ram_q;

    always_comb begin
        if (i_in_item.block_start) begin
            e_phase = PH_HEADER;
            e_cnt   = '0;
            e_bits  = '0;
            e_left  = '0;
            e_prev  = '0;
            e_good  = 1'b1;
            e_cur   = '0;
            e_off   = '0;
        end else begin
            e_phase = r_phase;
            e_cnt   = r_cnt;
            e_bits  = r_bits;
            e_left  = r_left;
            e_prev  = r_prev;
            e_good  = r_good;
            e_cur   = r_cur;
            e_off   = r_off;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_bits       = r_bits;
        n_left       = r_left;
        n_prev       = r_prev;
        n_good       = r_good;
        n_cur        = r_cur;
        n_off        = r_off;
        n_last_len   = r_last_len;
        n_low        = r_low;
        ram_we       = 1'b0;
        ram_waddr    = e_cur[AW-1:0];
        ram_wdata    = '0;
        res_valid    = 1'b0;
        res          = '0;
        cat          = {e_bits, i_in_item.data_byte};
        avail        = AVW'(e_left) + AVW'(BYTE_W);
        shift        = avail - AVW'(BW);
        border       = BW'(cat >> shift);
        new_left     = LW'(shift);
        cnt_inc      = (HCW + 1)'(e_cnt) + (HCW + 1)'(1);
        sz_border    = SZ_W'(border) - SZ_W'(e_prev);
        len_clamped  = clamp_len(sz_border, r_hp, r_payload);
        sz_last      = '0;
        last_clamped = '0;
        off_inc      = (OFF_W + 1)'(e_off) + (OFF_W + 1)'(1);
        nl           = '0;
        if (acc) begin
            n_phase = e_phase;
            n_cnt   = e_cnt;
            n_bits  = e_bits;
            n_left  = e_left;
            n_prev  = e_prev;
            n_good  = e_good;
            n_cur   = e_cur;
            n_off   = e_off;
            unique case (e_phase)
                PH_HEADER: begin
                    if (e_cur < nb) begin
                        if (avail >= AVW'(BW)) begin
                            n_left = new_left;
                            n_bits = (BW - 1)'(cat & ~({CAT_W{1'b1}} << new_left));
                            if (border >= e_prev) begin
                                ram_we              = 1'b1;
                                ram_wdata           = len_clamped;
                                n_low[e_cur[AW-1:0]] = len_clamped > LEN_W'(r_hp);
                            end else begin
                                n_good = 1'b0;
                            end
                            n_prev = border;
                            n_cur  = e_cur + FW'(1);
                        end else begin
                            n_left = avail[LW-1:0];
                            n_bits = cat[BW-2:0];
                        end
                    end else begin
                        n_left = '0;
                        n_bits = '0;
                    end
                    n_cnt = cnt_inc[HCW-1:0];
                    if (cnt_inc >= (HCW + 1)'(r_hdr)) begin
                        sz_last      = SZ_W'(r_payload) - SZ_W'(n_prev);
                        last_clamped = clamp_len(sz_last, r_hp, r_payload);
                        if (r_payload < 0) begin
                            n_good = 1'b0;
                        end else if (sz_last >= 0) begin
                            n_last_len        = last_clamped;
                            n_low[nb[AW-1:0]] = last_clamped > LEN_W'(r_hp);
                        end else begin
                            n_good = 1'b0;
                        end
                        res_valid       = 1'b1;
                        res.kind        = KIND_STATUS;
                        res.header_good = n_good;
                        n_phase         = n_good ? PH_HIGHER : PH_IDLE;
                        n_cur           = '0;
                        n_off           = '0;
                    end
                end
                PH_HIGHER: begin
                    if (e_cur >= r_n) begin
                        n_phase = PH_IDLE;
                    end else begin
                        res_valid        = 1'b1;
                        res.frame_index  = FI_W'(e_cur);
                        res.out_byte     = i_in_item.data_byte;
                        res.frame_length = cur_len;
                        res.header_good  = 1'b1;
                        if (e_off < OFF_W'(r_hp)) begin
                            res.kind        = KIND_HIGHER;
                            res.byte_offset = e_off;
                            res.frame_end   = (off_inc == (OFF_W + 1)'(r_hp))
                                              && !r_low[e_cur[AW-1:0]];
                            n_off           = off_inc[OFF_W-1:0];
                        end else begin
                            res.kind = KIND_CRC;
                            n_off    = '0;
                            n_cur    = e_cur + FW'(1);
                            if (e_cur + FW'(1) >= r_n) begin
                                nl    = next_lower(r_low, '0, r_n);
                                n_cur = nl;
                                if (nl >= r_n) begin
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_phase = PH_LOWER;
                                    n_off   = OFF_W'(r_hp);
                                end
                            end
                        end
                    end
                end
                PH_LOWER: begin
                    if (e_cur >= r_n) begin
                        n_phase = PH_IDLE;
                    end else begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_LOWER;
                        res.frame_index  = FI_W'(e_cur);
                        res.byte_offset  = e_off;
                        res.out_byte     = i_in_item.data_byte;
                        res.frame_length = cur_len;
                        res.header_good  = 1'b1;
                        res.frame_end    = off_inc >= (OFF_W + 1)'(cur_len);
                        n_off            = off_inc[OFF_W-1:0];
                        if (off_inc >= (OFF_W + 1)'(cur_len)) begin
                            nl    = next_lower(r_low, e_cur + FW'(1), r_n);
                            n_cur = nl;
                            if (nl >= r_n) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_off = OFF_W'(r_hp);
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        ram_raddr = (n_cur < FW'(MAX_FRAMES)) ? n_cur[AW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cnt   <= '0;
            r_bits  <= '0;
            r_left  <= '0;
            r_prev  <= '0;
            r_good  <= 1'b1;
            r_cur   <= '0;
            r_off   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
            r_left  <= n_left;
            r_prev  <= n_prev;
            r_good  <= n_good;
            r_cur   <= n_cur;
            r_off   <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_len <= n_last_len;
        r_low      <= n_low;
    end

    aacsfp_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_FRAMES)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    aacsfp_skid u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_item  (res),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

@@ sim/aac_superframe_partitioner_tb.sv @@
// Self-checking testbench of the audio super-frame partitioner with a byte label predictor.
module aac_superframe_partitioner_tb;
    import aacsfp_pkg::*;

    localparam int BW           = BORDER_WIDTH_DEF;
    localparam int HDR_BITS     = 8 * (((FRAMES_HI - 1) * BW + 7) / 8);
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 4;

    typedef enum int {
        SF_HEADER,
        SF_HIGHER,
        SF_LOWER,
        SF_IDLE
    } t_sf_phase;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_item;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_RATE;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    t_in  bytes_to_send[$];
    t_out expected_labels[$];
    int   queued_in_phase   = 0;
    int   sender_idle_pct   = 0;
    int   receiver_idle_pct = 0;
    int   hold_requests     = 0;
    int   holds_served      = 0;
    int   hold_left         = 0;
    int   errors            = 0;

    bit        cfg_rate  = 1'b0;
    bit        cfg_text  = 1'b0;
    int        cfg_block = 0;
    int        cfg_hprot = 0;
    t_sf_phase sf_phase    = SF_HEADER;
    int        hdr_count   = 0;
    int        border_acc  = 0;
    int        last_border = 0;
    int        cur_frame   = 0;
    int        frame_off   = 0;
    bit        hdr_ok      = 1'b1;
    int        frame_len [MAX_FRAMES_DEF] = '{default: 0};

    aac_superframe_partitioner i_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int frames_per_block();
        int n;
        n = cfg_rate ? FRAMES_HI : FRAMES_LO;
        return (n > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : n;
    endfunction

    function automatic int header_len();
        return ((frames_per_block() - 1) * BW + 7) / 8;
    endfunction

    function automatic int payload_bytes();
        return cfg_block - (cfg_text ? TEXT_BYTES : 0) - header_len() - frames_per_block();
    endfunction

    function automatic int hp_count();
        int v;
        v = cfg_hprot - header_len() - frames_per_block();
        return (v < 0) ? 0 : v / frames_per_block();
    endfunction

    function automatic int clamp_frame(input int size);
        int hp;
        int pl;
        hp = hp_count();
        pl = payload_bytes();
        if (size < hp) begin
            size = hp;
        end else if (size > pl) begin
            size = pl;
        end
        if (size < 0) begin
            size = 0;
        end
        if (size > LEN_MAX) begin
            size = LEN_MAX;
        end
        return size;
    endfunction

    function automatic int next_long_frame(input int f);
        while (f < frames_per_block() && frame_len[f] <= hp_count()) begin
            f++;
        end
        return f;
    endfunction

    function automatic void begin_superframe();
        hdr_count   = 0;
        border_acc  = 0;
        last_border = 0;
        hdr_ok      = 1'b1;
        sf_phase    = SF_HEADER;
        cur_frame   = 0;
        frame_off   = 0;
    endfunction

    // Returns 1 when the byte produces a result item and fills in the expected label.
    function automatic bit label_byte(input t_in it, output t_out lab);
        int n;
        int hp;
        int nb;
        int pending;
        int brd;
        int f;
        int o;
        int len;
        int pl;
        n   = frames_per_block();
        hp  = hp_count();
        lab = '0;
        if (it.block_start) begin
            begin_superframe();
        end
        if (sf_phase == SF_HEADER) begin
            nb         = n - 1;
            border_acc = (border_acc << 8) | int'(it.data_byte);
            pending    = (hdr_count + 1) * 8 - cur_frame * BW;
            if (cur_frame >= nb) begin
                pending = 0;
            end
            while (cur_frame < nb && pending >= BW) begin
                brd = (border_acc >> (pending - BW)) & ((1 << BW) - 1);
                if (brd >= last_border) begin
                    frame_len[cur_frame] = clamp_frame(brd - last_border);
                end else begin
                    hdr_ok = 1'b0;
                end
                last_border = brd;
                cur_frame++;
                pending -= BW;
            end
            border_acc = (pending != 0) ? (border_acc & ((1 << pending) - 1)) : 0;
            hdr_count  = (hdr_count + 1) & ((1 << CFG_W) - 1);
            if (hdr_count < header_len()) begin
                return 1'b0;
            end
            pl = payload_bytes();
            if (pl < 0) begin
                hdr_ok = 1'b0;
            end else if (pl >= last_border) begin
                frame_len[nb] = clamp_frame(pl - last_border);
            end else begin
                hdr_ok = 1'b0;
            end
            lab.kind        = KIND_STATUS;
            lab.header_good = hdr_ok;
            sf_phase        = hdr_ok ? SF_HIGHER : SF_IDLE;
            cur_frame       = 0;
            frame_off       = 0;
            return 1'b1;
        end
        if (cur_frame >= n) begin
            sf_phase = SF_IDLE;
            return 1'b0;
        end
        if (sf_phase == SF_IDLE) begin
            return 1'b0;
        end
        f   = cur_frame;
        o   = frame_off;
        len = frame_len[f];
        lab.frame_index  = FI_W'(f);
        lab.out_byte     = it.data_byte;
        lab.frame_length = LEN_W'(len);
        lab.header_good  = 1'b1;
        if (sf_phase == SF_HIGHER) begin
            if (o < hp) begin
                lab.kind        = KIND_HIGHER;
                lab.byte_offset = OFF_W'(o);
                lab.frame_end   = (o + 1 == hp) && (len <= hp);
                frame_off       = o + 1;
                return 1'b1;
            end
            lab.kind  = KIND_CRC;
            frame_off = 0;
            cur_frame = f + 1;
            if (cur_frame >= n) begin
                cur_frame = next_long_frame(0);
                if (cur_frame >= n) begin
                    sf_phase = SF_IDLE;
                end else begin
                    sf_phase  = SF_LOWER;
                    frame_off = hp;
                end
            end
            return 1'b1;
        end
        lab.kind        = KIND_LOWER;
        lab.byte_offset = OFF_W'(o);
        lab.frame_end   = (o + 1 >= len);
        frame_off       = o + 1;
        if (frame_off >= len) begin
            cur_frame = next_long_frame(f + 1);
            if (cur_frame >= n) begin
                sf_phase = SF_IDLE;
            end else begin
                frame_off = hp;
            end
        end
        return 1'b1;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : drive_bytes
        t_out lab;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (label_byte(i_in_item, lab)) begin
                    expected_labels.insert(expected_labels.size(), lab);
                end
                void'(bytes_to_send.pop_front());
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (bytes_to_send.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= bytes_to_send[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_labels
        t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_labels.size() == 0) begin
                    $error("result item with no expected label: %p", o_out_item);
                    errors++;
                end else begin
                    want = expected_labels.pop_front();
                    compare_field("kind", want.kind, o_out_item.kind);
                    compare_field("frame_index", want.frame_index, o_out_item.frame_index);
                    compare_field("byte_offset", want.byte_offset, o_out_item.byte_offset);
                    compare_field("out_byte", want.out_byte, o_out_item.out_byte);
                    compare_field("frame_length", want.frame_length, o_out_item.frame_length);
                    compare_field("header_good", want.header_good, o_out_item.header_good);
                    compare_field("frame_end", want.frame_end, o_out_item.frame_end);
                end
            end
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
            end
        end
    end

    function automatic void push_byte(input logic [7:0] value, input bit start);
        t_in it;
        it.data_byte   = value;
        it.block_start = start;
        bytes_to_send.insert(bytes_to_send.size(), it);
        queued_in_phase++;
    endfunction

    function automatic void queue_header(input int borders[$]);
        logic [HDR_BITS-1:0] bits;
        int k;
        bits = '0;
        for (k = 0; k < borders.size(); k++) begin
            bits[HDR_BITS - 1 - BW * k -: BW] = BW'(borders[k]);
        end
        for (k = 0; k < header_len(); k++) begin
            push_byte(bits[HDR_BITS - 1 - 8 * k -: 8], k == 0);
        end
    endfunction

    // A broken super-frame has decreasing borders or a border past the payload.
    function automatic void queue_superframe(input bit broken);
        int borders[$];
        int n;
        int pl;
        int hp;
        int top;
        int nbytes;
        int k;
        n   = frames_per_block();
        pl  = payload_bytes();
        hp  = hp_count();
        top = (pl > 0 && pl < LEN_MAX) ? pl : LEN_MAX;
        for (k = 0; k < n - 1; k++) begin
            borders.insert(borders.size(), $urandom_range(top, 0));
        end
        borders.sort();
        if (broken) begin
            if (pl >= 0 && pl < LEN_MAX && $urandom_range(1, 0) == 1) begin
                borders[n - 2] = pl + 1;
            end else begin
                k = $urandom_range(n - 3, 0);
                if (borders[k] == 0) begin
                    borders[k]     = $urandom_range(LEN_MAX, 1);
                    borders[k + 1] = 0;
                end else begin
                    borders[k + 1] = $urandom_range(borders[k] - 1, 0);
                end
            end
        end
        queue_header(borders);
        if (broken) begin
            nbytes = $urandom_range(6, 0);
        end else begin
            nbytes = ((pl > 0) ? pl : 0) + n * (hp + 1) + (cfg_text ? TEXT_BYTES : 0)
                     + $urandom_range(3, 0);
            if (nbytes > 100) begin
                nbytes = $urandom_range(100, 16);
            end
        end
        for (k = 0; k < nbytes; k++) begin
            push_byte(8'($urandom_range(255, 0)), 1'b0);
        end
    endfunction

    function automatic void queue_noise();
        int k;
        int cnt;
        cnt = $urandom_range(4, 1);
        for (k = 0; k < cnt; k++) begin
            push_byte(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0);
        end
    endfunction

    task automatic run_phase(input int budget);
        int r;
        @(negedge i_clk);
        queued_in_phase = 0;
        while (queued_in_phase < budget) begin
            r = $urandom_range(99, 0);
            if (r < 10 && queued_in_phase > 0) begin
                queue_noise();
            end else begin
                queue_superframe(r < 22);
            end
        end
    endtask

    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || i_in_valid || expected_labels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input bit rate, input bit text, input int blk, input int hprot);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_RATE;
        i_cfg_data  <= CFG_W'(rate);
        @(posedge i_clk);
        i_cfg_index <= CFG_TEXT;
        i_cfg_data  <= CFG_W'(text);
        @(posedge i_clk);
        i_cfg_index <= CFG_BLOCK;
        i_cfg_data  <= CFG_W'(blk);
        @(posedge i_clk);
        i_cfg_index <= CFG_HPROT;
        i_cfg_data  <= CFG_W'(hprot);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_rate  = rate;
        cfg_text  = text;
        cfg_block = blk;
        cfg_hprot = hprot;
    endtask

    initial begin : stimulus
        int dir_borders[$];
        int k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sender_idle_pct   = 18;
        receiver_idle_pct = 59;

        // The first bytes carry no block start and meet the reset settings, so the header is bad.
        @(negedge i_clk);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b0);
        wait_idle();

        // Short and empty-border frames with one higher byte each, then a text tail.
        set_config(1'b0, 1'b1, 21, 16);
        dir_borders = {0, 1, 1, 3};
        @(negedge i_clk);
        queue_header(dir_borders);
        for (k = 0; k < 14; k++) begin
            push_byte(8'($urandom_range(255, 0)), 1'b0);
        end
        wait_idle();

        set_config(1'b0, 1'b0, 31, 0);
        run_phase(30);
        wait_idle();
        set_config(1'b1, 1'b0, 64, 44);
        run_phase(30);
        wait_idle();

        sender_idle_pct   = 59;
        receiver_idle_pct = 18;
        set_config(1'b1, 1'b1, 8191, 8191);
        run_phase(30);
        wait_idle();
        set_config(1'b0, 1'b1, 0, 0);
        run_phase(30);
        wait_idle();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_config(1'b1, 1'b1, 78, 54);
        run_phase(40);
        hold_requests++;
        wait_idle();
        set_config(1'b0, 1'b0, 40, 60);
        run_phase(30);
        wait_idle();
        set_config(1'b1, 1'b0, 54, 0);
        run_phase(30);
        wait_idle();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(20 * 200000);
        $display("Verification failed");
        $finish;
    end

endmodule
